### rtl/core/gbnc_pkg.sv
// shared constants and types for the grid branch node counter
package gbnc_pkg;

    // default grid limits for the storage
    localparam int DEFAULT_MAX_COLUMNS = 16;
    localparam int DEFAULT_MAX_ROWS    = 16;

    // size registers never grant more than this many columns or rows
    localparam int SIZE_LIMIT = 16;

    // configuration port
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_LENGTH = 1'd1;
    localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 5'd4;
    localparam logic [CFG_W-1:0] GRID_LENGTH_RESET = 5'd3;

    // input field widths
    localparam int CRD_W   = 4;
    localparam int DIR_W   = 2;
    localparam int COUNT_W = 9;

    // coordinate width inside the neighbour unit, holds one past the limit
    localparam int NCRD_W = 5;

    // visit mark generation width
    localparam int EPOCH_W = 8;

    // actions
    localparam logic ACT_CONNECT = 1'b0;
    localparam logic ACT_MEASURE = 1'b1;

    // directions
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

    // result of the neighbour unit
    typedef struct packed {
        logic              src_ok;
        logic              nbr_ok;
        logic [NCRD_W-1:0] nx;
        logic [NCRD_W-1:0] ny;
    } t_nbr;

    function automatic logic [DIR_W-1:0] opposite_dir(input logic [DIR_W-1:0] d);
        opposite_dir = DIR_W'(d + DIR_W'(2));
    endfunction

    function automatic logic [3:0] dir_mask(input logic [DIR_W-1:0] d);
        dir_mask = 4'b0001 << d;
    endfunction

endpackage

### rtl/core/grid_branch_node_counter_top.sv
// grid branch node counter: edge store, connect and depth-first branch measure
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------------
//  command  | in        | start, busy             | i_action i_cell_x i_cell_y i_direction
//  result   | out       | o_done (one-cycle beat) | o_node_count o_accepted
//  config   | in        | i_cfg_we                | i_cfg_index i_cfg_wdata
//
//  a command beat is taken when start is high and busy is low; busy drops in the
//  cycle the result beat shows, so a new command may follow at once
//  out-of-grid commands: result in the cycle after the beat; connect: read and write
//  back the edge word of the cell, then of the neighbour; measure with no such edge:
//  read it and answer zero; otherwise pop each reached cell, read its edges and scan
//  its four directions on the single-port edge, visit and stack memories and one neighbour unit
//  reset: a clearing pass over all 2**(clog2(MAX_COLUMNS)+clog2(MAX_ROWS)) addresses (256 by
//  default) wipes edges and visit marks; busy stays high meanwhile
//  once all 255 mark generations are used, the next measure repeats that pass on
//  the visit marks alone before walking
//  results cannot be stalled; config writes are taken in any cycle
module grid_branch_node_counter_top
    import gbnc_pkg::*;
#(
    parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEFAULT_MAX_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_action,
    input  logic [CRD_W-1:0]     i_cell_x,
    input  logic [CRD_W-1:0]     i_cell_y,
    input  logic [DIR_W-1:0]     i_direction,
    // result channel
    output logic                 o_done,
    output logic [COUNT_W-1:0]   o_node_count,
    output logic                 o_accepted,
    // config channel
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    // address of a cell is {row, column}
    localparam int XW    = $clog2(MAX_COLUMNS);
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;

    // usable size limits
    localparam int WLIM = (MAX_COLUMNS < SIZE_LIMIT) ? MAX_COLUMNS : SIZE_LIMIT;
    localparam int HLIM = (MAX_ROWS < SIZE_LIMIT) ? MAX_ROWS : SIZE_LIMIT;

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_C_RDS = 4'd2;
    localparam logic [3:0] S_C_WRS = 4'd3;
    localparam logic [3:0] S_C_RDN = 4'd4;
    localparam logic [3:0] S_C_WRN = 4'd5;
    localparam logic [3:0] S_M_RDS = 4'd6;
    localparam logic [3:0] S_M_CHK = 4'd7;
    localparam logic [3:0] S_M_MRK = 4'd8;
    localparam logic [3:0] S_POP   = 4'd9;
    localparam logic [3:0] S_GET   = 4'd10;
    localparam logic [3:0] S_EDGE  = 4'd11;
    localparam logic [3:0] S_SCAN  = 4'd12;
    localparam logic [3:0] S_TEST  = 4'd13;

    localparam logic [DIR_W-1:0] LAST_DIR = DIR_DOWN;

    // control and config registers
    logic [3:0]          r_state;
    logic [AW-1:0]       r_clr;
    logic                r_clr_edge;
    logic [CFG_W-1:0]    r_gw;
    logic [CFG_W-1:0]    r_gl;
    logic [EPOCH_W-1:0]  r_epoch;
    logic [AW-1:0]       r_depth;
    logic [COUNT_W-1:0]  r_count;
    logic                r_done;

    // payload registers
    logic [DIR_W-1:0]    r_dir;
    logic [XW-1:0]       r_sx;
    logic [YW-1:0]       r_sy;
    logic [XW-1:0]       r_nx;
    logic [YW-1:0]       r_ny;
    logic [XW-1:0]       r_cur_x;
    logic [YW-1:0]       r_cur_y;
    logic [3:0]          r_bits;
    logic [DIR_W-1:0]    r_k;
    logic [COUNT_W-1:0]  r_node_count;
    logic                r_accepted;

    // memories and their registered read data
    logic [3:0]          r_edge_mem [DEPTH];
    logic [EPOCH_W-1:0]  r_vis_mem  [DEPTH];
    logic [AW-1:0]       r_stk_mem  [DEPTH];
    logic [3:0]          r_edge_q;
    logic [EPOCH_W-1:0]  r_vis_q;
    logic [AW-1:0]       r_stk_q;

    // memory port controls
    logic                edge_we;
    logic [AW-1:0]       edge_addr;
    logic [3:0]          edge_wd;
    logic                vis_we;
    logic [AW-1:0]       vis_addr;
    logic [EPOCH_W-1:0]  vis_wd;
    logic                stk_we;
    logic [AW-1:0]       stk_addr;

    // shared neighbour unit
    logic [CFG_W-1:0]    used_w;
    logic [CFG_W-1:0]    used_h;
    logic [NCRD_W-1:0]   sel_x;
    logic [NCRD_W-1:0]   sel_y;
    logic [DIR_W-1:0]    sel_d;
    t_nbr                nbr;
    logic                cmd_take;
    logic                cmd_ok;
    logic [AW-1:0]       src_addr;
    logic [AW-1:0]       nbr_addr;
    logic [AW-1:0]       cur_addr;

    assign used_w = (r_gw > CFG_W'(WLIM)) ? CFG_W'(WLIM) : r_gw;
    assign used_h = (r_gl > CFG_W'(HLIM)) ? CFG_W'(HLIM) : r_gl;

    // idle: the incoming command, otherwise the cell being expanded
    assign sel_x = (r_state == S_IDLE) ? NCRD_W'(i_cell_x) : NCRD_W'(r_cur_x);
    assign sel_y = (r_state == S_IDLE) ? NCRD_W'(i_cell_y) : NCRD_W'(r_cur_y);
    assign sel_d = (r_state == S_IDLE) ? i_direction : r_k;

    always_comb begin
        nbr.nx     = sel_x;
        nbr.ny     = sel_y;
        nbr.nbr_ok = 1'b1;
        nbr.src_ok = (sel_x < NCRD_W'(used_w)) && (sel_y < NCRD_W'(used_h));
        case (sel_d)
            DIR_LEFT: begin
                if (sel_x == '0) nbr.nbr_ok = 1'b0;
                else nbr.nx = sel_x - NCRD_W'(1);
            end
            DIR_UP: begin
                if (sel_y == '0) nbr.nbr_ok = 1'b0;
                else nbr.ny = sel_y - NCRD_W'(1);
            end
            DIR_RIGHT: nbr.nx = sel_x + NCRD_W'(1);
            DIR_DOWN:  nbr.ny = sel_y + NCRD_W'(1);
            default:   nbr.nbr_ok = 1'b0;
        endcase
        if (nbr.nx >= NCRD_W'(used_w) || nbr.ny >= NCRD_W'(used_h)) nbr.nbr_ok = 1'b0;
    end

    assign cmd_take = start && !busy;
    assign cmd_ok   = nbr.src_ok && nbr.nbr_ok;
    assign src_addr = {r_sy, r_sx};
    assign nbr_addr = {r_ny, r_nx};
    assign cur_addr = {YW'(nbr.ny), XW'(nbr.nx)};

    // memory port selection
    always_comb begin
        edge_we   = 1'b0;
        edge_addr = src_addr;
        edge_wd   = r_edge_q | dir_mask(r_dir);
        vis_we    = 1'b0;
        vis_addr  = nbr_addr;
        vis_wd    = r_epoch;
        stk_we    = 1'b0;
        stk_addr  = r_depth;
        case (r_state)
            S_CLEAR: begin
                edge_we   = r_clr_edge;
                edge_addr = r_clr;
                edge_wd   = '0;
                vis_we    = 1'b1;
                vis_addr  = r_clr;
                vis_wd    = '0;
            end
            S_C_WRS: edge_we = 1'b1;
            S_C_RDN: edge_addr = nbr_addr;
            S_C_WRN: begin
                edge_we   = 1'b1;
                edge_addr = nbr_addr;
                edge_wd   = r_edge_q | dir_mask(opposite_dir(r_dir));
            end
            S_M_CHK: begin
                vis_we   = r_edge_q[r_dir];
                vis_addr = src_addr;
            end
            S_M_MRK: begin
                // start cell is marked and pushed as the first stack entry
                vis_we   = 1'b1;
                stk_we   = 1'b1;
                stk_addr = '0;
            end
            S_POP:  stk_addr = r_depth - AW'(1);
            S_GET:  edge_addr = r_stk_q;
            S_SCAN: vis_addr = cur_addr;
            S_TEST: begin
                vis_we = (r_vis_q != r_epoch);
                stk_we = (r_vis_q != r_epoch);
            end
            default: begin
            end
        endcase
    end

    // single-port memories with registered reads
    always_ff @(posedge i_clk) begin
        if (edge_we) r_edge_mem[edge_addr] <= edge_wd;
        r_edge_q <= r_edge_mem[edge_addr];
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) r_vis_mem[vis_addr] <= vis_wd;
        r_vis_q <= r_vis_mem[vis_addr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) r_stk_mem[stk_addr] <= nbr_addr;
        r_stk_q <= r_stk_mem[stk_addr];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= GRID_WIDTH_RESET;
            r_gl <= GRID_LENGTH_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_GRID_WIDTH) r_gw <= i_cfg_wdata;
            if (i_cfg_index == REG_GRID_LENGTH) r_gl <= i_cfg_wdata;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_clr_edge <= 1'b1;
            r_epoch    <= '0;
            r_depth    <= '0;
            r_count    <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        if (r_clr_edge) begin
                            r_state <= S_IDLE;
                        end else begin
                            // mark generations restart after the wipe
                            r_epoch <= EPOCH_W'(1);
                            r_state <= S_M_RDS;
                        end
                    end
                end
                S_IDLE: begin
                    if (cmd_take) begin
                        r_dir <= i_direction;
                        r_sx  <= XW'(i_cell_x);
                        r_sy  <= YW'(i_cell_y);
                        r_nx  <= XW'(nbr.nx);
                        r_ny  <= YW'(nbr.ny);
                        if (!cmd_ok) begin
                            r_done       <= 1'b1;
                            r_node_count <= '0;
                            r_accepted   <= 1'b0;
                        end else if (i_action == ACT_CONNECT) begin
                            r_state <= S_C_RDS;
                        end else if (r_epoch == '1) begin
                            r_clr      <= '0;
                            r_clr_edge <= 1'b0;
                            r_state    <= S_CLEAR;
                        end else begin
                            r_epoch <= r_epoch + EPOCH_W'(1);
                            r_state <= S_M_RDS;
                        end
                    end
                end
                S_C_RDS: r_state <= S_C_WRS;
                S_C_WRS: r_state <= S_C_RDN;
                S_C_RDN: r_state <= S_C_WRN;
                S_C_WRN: begin
                    r_done       <= 1'b1;
                    r_node_count <= '0;
                    r_accepted   <= 1'b1;
                    r_state      <= S_IDLE;
                end
                S_M_RDS: r_state <= S_M_CHK;
                S_M_CHK: begin
                    if (r_edge_q[r_dir]) begin
                        r_state <= S_M_MRK;
                    end else begin
                        r_done       <= 1'b1;
                        r_node_count <= '0;
                        r_accepted   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_M_MRK: begin
                    r_depth <= AW'(1);
                    r_count <= COUNT_W'(1);
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (r_depth == '0) begin
                        r_done       <= 1'b1;
                        r_node_count <= r_count;
                        r_accepted   <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_depth <= r_depth - AW'(1);
                        r_state <= S_GET;
                    end
                end
                S_GET: begin
                    r_cur_x <= r_stk_q[XW-1:0];
                    r_cur_y <= r_stk_q[AW-1:XW];
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    r_bits  <= r_edge_q;
                    r_k     <= DIR_LEFT;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_bits[r_k] && nbr.nbr_ok) begin
                        r_nx    <= XW'(nbr.nx);
                        r_ny    <= YW'(nbr.ny);
                        r_state <= S_TEST;
                    end else if (r_k == LAST_DIR) begin
                        r_state <= S_POP;
                    end else begin
                        r_k <= r_k + DIR_W'(1);
                    end
                end
                S_TEST: begin
                    if (r_vis_q != r_epoch) begin
                        r_depth <= r_depth + AW'(1);
                        r_count <= r_count + COUNT_W'(1);
                    end
                    if (r_k == LAST_DIR) begin
                        r_state <= S_POP;
                    end else begin
                        r_k     <= r_k + DIR_W'(1);
                        r_state <= S_SCAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_node_count = r_node_count;
    assign o_accepted   = r_accepted;

    // result beat only shows while the command side is open again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    // a rejected result carries no count
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_accepted) |-> (o_node_count == '0))
        else $error("rejected result with nonzero count");

    // out-of-grid commands answer in the next cycle
    a_reject_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_take && !cmd_ok) |=> (o_done && !o_accepted))
        else $error("out-of-grid command not answered at once");

    // a walk always runs with a live mark generation
    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEST || r_state == S_M_MRK) |-> (r_epoch != '0))
        else $error("visit marks used with a dead generation");

endmodule

### tb/sv/branch_count_checker.sv
// result checker for the grid branch node counter: edge map model and result compare
module branch_count_checker
    import gbnc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 i_action,
    input  logic [CRD_W-1:0]     i_cell_x,
    input  logic [CRD_W-1:0]     i_cell_y,
    input  logic [DIR_W-1:0]     i_direction,
    input  logic                 o_done,
    input  logic [COUNT_W-1:0]   o_node_count,
    input  logic                 o_accepted,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output int                   fail_count,
    output int                   matched_count
);

    localparam int COLS  = DEFAULT_MAX_COLUMNS;
    localparam int ROWS  = DEFAULT_MAX_ROWS;
    localparam int CELLS = COLS * ROWS;

    typedef struct packed {
        logic [COUNT_W-1:0] node_count;
        logic               accepted;
    } branch_result_t;

    logic [3:0]       edge_map [CELLS];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] length_reg;
    branch_result_t   expected_q [$];
    int               errors;
    int               match_total;

    function automatic int span(input logic [CFG_W-1:0] r, input int lim);
        int v;
        v = r;
        if (v > SIZE_LIMIT) v = SIZE_LIMIT;
        if (v > lim) v = lim;
        return v;
    endfunction

    function automatic bit in_grid(input int x, input int y);
        return x < span(width_reg, COLS) && y < span(length_reg, ROWS);
    endfunction

    // neighbour in direction d, zero when it falls off the grid in use
    function automatic bit step_cell(input int x, input int y, input logic [DIR_W-1:0] d,
                                     output int nx, output int ny);
        int ax;
        int ay;
        ax = x;
        ay = y;
        nx = 0;
        ny = 0;
        case (d)
            DIR_LEFT: begin
                if (ax == 0) return 1'b0;
                ax--;
            end
            DIR_UP: begin
                if (ay == 0) return 1'b0;
                ay--;
            end
            DIR_RIGHT: ax++;
            default: ay++;
        endcase
        if (!in_grid(ax, ay)) return 1'b0;
        nx = ax;
        ny = ay;
        return 1'b1;
    endfunction

    // cells reachable from first without entering src, first included
    function automatic int reach_count(input int src, input int first);
        bit seen [CELLS];
        int stack [CELLS];
        int depth;
        int total;
        int c;
        int nx;
        int ny;
        int nb;
        foreach (seen[i]) seen[i] = 1'b0;
        seen[src]   = 1'b1;
        seen[first] = 1'b1;
        stack[0]    = first;
        depth       = 1;
        total       = 1;
        while (depth > 0) begin
            depth--;
            c = stack[depth];
            for (int k = 0; k < 4; k++) begin
                if (!edge_map[c][k]) continue;
                if (!step_cell(c % COLS, c / COLS, DIR_W'(k), nx, ny)) continue;
                nb = ny * COLS + nx;
                if (seen[nb]) continue;
                seen[nb]     = 1'b1;
                stack[depth] = nb;
                depth++;
                total++;
            end
        end
        return total;
    endfunction

    function automatic branch_result_t apply_command(input logic act,
                                                     input logic [CRD_W-1:0] x,
                                                     input logic [CRD_W-1:0] y,
                                                     input logic [DIR_W-1:0] d);
        branch_result_t   r;
        logic [DIR_W-1:0] back;
        int               nx;
        int               ny;
        int               s;
        int               n;
        bit               ok;
        r    = '0;
        back = d + DIR_W'(2);
        ok   = in_grid(x, y) && step_cell(x, y, d, nx, ny);
        if (ok) begin
            s = y * COLS + x;
            n = ny * COLS + nx;
            if (act == ACT_CONNECT) begin
                edge_map[s][d]    = 1'b1;
                edge_map[n][back] = 1'b1;
            end else if (edge_map[s][d]) begin
                r.node_count = COUNT_W'(reach_count(s, n));
            end
        end
        r.accepted = ok;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d (result %0d)", what, got, want, match_total);
        errors++;
    endtask

    always @(posedge i_clk) begin
        branch_result_t want;
        if (!i_rst_n) begin
            foreach (edge_map[i]) edge_map[i] = 4'b0000;
            width_reg  = GRID_WIDTH_RESET;
            length_reg = GRID_LENGTH_RESET;
            expected_q.delete();
            errors      = 0;
            match_total = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GRID_WIDTH:  width_reg  = i_cfg_wdata;
                    REG_GRID_LENGTH: length_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            // a result beat belongs to an earlier command, so check before predicting
            if (o_done === 1'b1) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding", o_node_count, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (o_node_count !== want.node_count)
                        report_mismatch("node_count", o_node_count, want.node_count);
                    if (o_accepted !== want.accepted)
                        report_mismatch("accepted", o_accepted, want.accepted);
                    match_total++;
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                expected_q.push_back(apply_command(i_action, i_cell_x, i_cell_y, i_direction));
        end
        fail_count    <= errors;
        matched_count <= match_total;
    end

endmodule

### tb/sv/testbench.sv
// testbench top for the grid branch node counter: stimulus, watchdog and verdict
module testbench
    import gbnc_pkg::*;
();

    // random part size and how many of its last beats run without idling
    localparam int RANDOM_ITEMS = 555;
    localparam int QUIET_TAIL   = 60;
    // the watchdog limit lies above the longest dense 16x16 measure plus the clearing pass
    localparam int IDLE_LIMIT   = 20000;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic                 i_action     = ACT_CONNECT;
    logic [CRD_W-1:0]     i_cell_x     = '0;
    logic [CRD_W-1:0]     i_cell_y     = '0;
    logic [DIR_W-1:0]     i_direction  = DIR_LEFT;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = REG_GRID_WIDTH;
    logic [CFG_W-1:0]     i_cfg_wdata  = '0;
    logic                 busy;
    logic                 o_done;
    logic [COUNT_W-1:0]   o_node_count;
    logic                 o_accepted;

    int fail_count;
    int matched_count;
    int sent_count    = 0;
    int measure_count = 0;
    int setting_count = 0;
    int random_sent   = 0;
    int idle_cycles   = 0;
    bit idle_bursts   = 1'b1;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    grid_branch_node_counter_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .i_direction  (i_direction),
        .o_done       (o_done),
        .o_node_count (o_node_count),
        .o_accepted   (o_accepted),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    branch_count_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_cell_x      (i_cell_x),
        .i_cell_y      (i_cell_y),
        .i_direction   (i_direction),
        .o_done        (o_done),
        .o_node_count  (o_node_count),
        .o_accepted    (o_accepted),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .fail_count    (fail_count),
        .matched_count (matched_count)
    );

    // cycles with neither a command beat nor a result beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("watchdog: no beat for %0d cycles, %0d of %0d results seen",
                 IDLE_LIMIT, matched_count, sent_count);
        $display("FAILED: results differ");
        $finish;
    end

    // one command beat; start stays high into the next call unless a gap is drawn
    task automatic send_cmd(input logic act, input logic [CRD_W-1:0] x,
                            input logic [CRD_W-1:0] y, input logic [DIR_W-1:0] d);
        if (idle_bursts && $urandom_range(3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_action    <= act;
        i_cell_x    <= x;
        i_cell_y    <= y;
        i_direction <= d;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sent_count++;
        if (act == ACT_MEASURE) measure_count++;
    endtask

    // stop sending and wait until every outstanding result beat has come back
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (matched_count != sent_count) @(posedge i_clk);
    endtask

    // size registers only change while nothing is in flight
    task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] l);
        drain;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_GRID_WIDTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_index <= REG_GRID_LENGTH;
        i_cfg_wdata <= l;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        setting_count++;
    endtask

    initial begin
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] l;
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic             act;
        int               uw;
        int               uh;
        int               n_items;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on the reset grid of 4 columns by 3 rows
        send_cmd(ACT_MEASURE, 4'd0, 4'd0, DIR_RIGHT);   // edge not there yet
        send_cmd(ACT_CONNECT, 4'd0, 4'd0, DIR_LEFT);    // neighbour off the left side
        send_cmd(ACT_CONNECT, 4'd0, 4'd0, DIR_UP);      // neighbour off the top
        send_cmd(ACT_CONNECT, 4'd3, 4'd2, DIR_RIGHT);   // neighbour past last column
        send_cmd(ACT_CONNECT, 4'd3, 4'd2, DIR_DOWN);    // neighbour past last row
        send_cmd(ACT_CONNECT, 4'd15, 4'd15, DIR_RIGHT); // cell far outside
        send_cmd(ACT_MEASURE, 4'd4, 4'd0, DIR_LEFT);    // cell outside, neighbour inside
        send_cmd(ACT_CONNECT, 4'd0, 4'd0, DIR_RIGHT);
        send_cmd(ACT_CONNECT, 4'd1, 4'd0, DIR_RIGHT);
        send_cmd(ACT_CONNECT, 4'd2, 4'd0, DIR_DOWN);
        send_cmd(ACT_CONNECT, 4'd2, 4'd1, DIR_LEFT);
        send_cmd(ACT_CONNECT, 4'd1, 4'd1, DIR_UP);      // closes a loop
        send_cmd(ACT_CONNECT, 4'd0, 4'd0, DIR_RIGHT);   // same edge again
        send_cmd(ACT_MEASURE, 4'd0, 4'd0, DIR_RIGHT);
        send_cmd(ACT_MEASURE, 4'd1, 4'd0, DIR_LEFT);    // leaf branch
        send_cmd(ACT_MEASURE, 4'd2, 4'd1, DIR_UP);
        send_cmd(ACT_MEASURE, 4'd1, 4'd1, DIR_RIGHT);
        send_cmd(ACT_MEASURE, 4'd2, 4'd0, DIR_DOWN);
        send_cmd(ACT_MEASURE, 4'd3, 4'd2, DIR_UP);
        send_cmd(ACT_CONNECT, 4'd3, 4'd2, DIR_LEFT);

        // full grid, far corner becomes valid
        set_grid(5'd16, 5'd16);
        send_cmd(ACT_CONNECT, 4'd15, 4'd15, DIR_LEFT);
        send_cmd(ACT_CONNECT, 4'd14, 4'd15, DIR_UP);
        send_cmd(ACT_CONNECT, 4'd15, 4'd14, DIR_DOWN);
        send_cmd(ACT_MEASURE, 4'd15, 4'd15, DIR_LEFT);
        send_cmd(ACT_MEASURE, 4'd0, 4'd0, DIR_RIGHT);

        // shrunk grid, the walk meets edges that lead outside
        set_grid(5'd2, 5'd2);
        send_cmd(ACT_MEASURE, 4'd0, 4'd0, DIR_RIGHT);

        // zero width leaves no valid cell
        set_grid(5'd0, 5'd16);
        send_cmd(ACT_MEASURE, 4'd0, 4'd0, DIR_RIGHT);

        // oversized values saturate to the full grid
        set_grid(5'd31, 5'd17);
        send_cmd(ACT_MEASURE, 4'd15, 4'd15, DIR_UP);

        // single cell has no neighbours
        set_grid(5'd1, 5'd1);
        send_cmd(ACT_CONNECT, 4'd0, 4'd0, DIR_RIGHT);

        set_grid(5'd16, 5'd0);
        send_cmd(ACT_MEASURE, 4'd0, 4'd0, DIR_DOWN);

        // random part: mostly small grids, now and then a large or odd one
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(19))
                0: begin
                    w = 5'($urandom_range(12, 16));
                    l = 5'($urandom_range(12, 16));
                end
                1: begin
                    w = 5'($urandom_range(0, 31));
                    l = 5'($urandom_range(0, 3));
                end
                2: begin
                    w = 5'($urandom_range(1, 3));
                    l = 5'($urandom_range(17, 31));
                end
                default: begin
                    w = 5'($urandom_range(1, 6));
                    l = 5'($urandom_range(1, 6));
                end
            endcase
            set_grid(w, l);
            uw = (w > SIZE_LIMIT) ? SIZE_LIMIT : w;
            uh = (l > SIZE_LIMIT) ? SIZE_LIMIT : l;
            n_items = $urandom_range(15, 35);
            if (n_items > RANDOM_ITEMS - random_sent) n_items = RANDOM_ITEMS - random_sent;
            repeat (n_items) begin
                idle_bursts = (RANDOM_ITEMS - random_sent) > QUIET_TAIL;
                // most beats land inside the grid, the rest anywhere
                if (uw > 0 && uh > 0 && $urandom_range(99) < 85) begin
                    x = CRD_W'($urandom_range(uw - 1));
                    y = CRD_W'($urandom_range(uh - 1));
                end else begin
                    x = CRD_W'($urandom);
                    y = CRD_W'($urandom);
                end
                act = ($urandom_range(99) < 55) ? ACT_CONNECT : ACT_MEASURE;
                send_cmd(act, x, y, DIR_W'($urandom));
                random_sent++;
            end
        end

        drain;
        repeat (20) @(posedge i_clk);

        $display("run covered %0d commands (%0d measures) over %0d grid settings",
                 sent_count, measure_count, setting_count + 1);
        $display("%0d result beats checked, %0d mismatches", matched_count, fail_count);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/gbnc_pkg.sv
rtl/core/grid_branch_node_counter_top.sv
tb/sv/branch_count_checker.sv
tb/sv/testbench.sv
